>>> rtl/lntp_pkg.sv
// ----------------------------------------------------------------------------
// Layer name tag parser package
// Shared types, codes and character constants for the layer name tag parser.
// ----------------------------------------------------------------------------
package lntp_pkg;

   // Field widths fixed by the interface.
   localparam int CHAR_BITS      = 8;
   localparam int DURATION_BITS  = 31;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STATUS_BITS    = 3;
   localparam int DISPOSAL_BITS  = 2;
   localparam int PROGRESS_BITS  = 4;

   // Length of the disposal tags, parentheses included.
   localparam logic [PROGRESS_BITS-1:0] TAG_LENGTH = 4'd9;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEFAULT_DURATION = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_SUBSTITUTE  = 2'd1;

   // Configuration reset values.
   localparam logic [CSR_DATA_BITS-1:0] DEFAULT_DURATION_RESET = 16'd100;
   localparam logic [CSR_DATA_BITS-1:0] ZERO_SUBSTITUTE_RESET  = 16'd60;

   // Characters the scanners look for.
   localparam logic [CHAR_BITS-1:0] CHAR_OPEN_PAREN = 8'h28;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO       = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE       = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_M    = 8'h4D;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_M    = 8'h6D;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_S    = 8'h53;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_S    = 8'h73;

   // Phase of the timing tag scan.
   typedef enum logic [2:0] {
      PHASE_SEEK,
      PHASE_FIRST,
      PHASE_DIGITS,
      PHASE_TAIL,
      PHASE_DONE
   } phase_type;

   // Parse status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK,
      STATUS_NO_PAREN,
      STATUS_NO_DIGIT,
      STATUS_TOO_SHORT,
      STATUS_NO_MS
   } status_type;

   // Disposal modes.
   typedef enum logic [DISPOSAL_BITS-1:0] {
      DISPOSAL_NONE,
      DISPOSAL_COMBINE,
      DISPOSAL_REPLACE
   } disposal_type;

   // One accepted request as seen by the scanners.
   typedef struct packed {
      logic                 accept;
      logic                 last;
      logic [CHAR_BITS-1:0] ch;
   } step_type;

   // Character at a position of "(combine)" or "(replace)".
   function automatic logic [CHAR_BITS-1:0] tag_char(input logic pick_replace,
                                                     input logic [PROGRESS_BITS-1:0] pos);
      logic [CHAR_BITS-1:0] result;
      case (pos)
         4'd0:    result = CHAR_OPEN_PAREN;
         4'd1:    result = pick_replace ? 8'h72 : 8'h63;  // r / c
         4'd2:    result = pick_replace ? 8'h65 : 8'h6F;  // e / o
         4'd3:    result = pick_replace ? 8'h70 : 8'h6D;  // p / m
         4'd4:    result = pick_replace ? 8'h6C : 8'h62;  // l / b
         4'd5:    result = pick_replace ? 8'h61 : 8'h69;  // a / i
         4'd6:    result = pick_replace ? 8'h63 : 8'h6E;  // c / n
         4'd7:    result = 8'h65;                         // e
         4'd8:    result = 8'h29;                         // )
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

>>> rtl/lntp_disposal.sv
// ----------------------------------------------------------------------------
// Disposal tag matcher
// Tracks partial matches of "(combine)" and "(replace)" and latches the
// leftmost complete one. Presents the disposal that includes the current
// character.
// ----------------------------------------------------------------------------
module lntp_disposal (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lntp_pkg::step_type                    step,
   output lntp_pkg::disposal_type                disposal_next
);

   logic [lntp_pkg::PROGRESS_BITS-1:0] combine_progress_ff;
   logic [lntp_pkg::PROGRESS_BITS-1:0] combine_progress_in;
   logic [lntp_pkg::PROGRESS_BITS-1:0] replace_progress_ff;
   logic [lntp_pkg::PROGRESS_BITS-1:0] replace_progress_in;
   lntp_pkg::disposal_type             disposal_ff;
   logic [lntp_pkg::PROGRESS_BITS-1:0] combine_step;
   logic [lntp_pkg::PROGRESS_BITS-1:0] replace_step;
   logic                               is_open;

   assign is_open = (step.ch == lntp_pkg::CHAR_OPEN_PAREN);

   // Advance each matcher; a miss restarts at one on an open parenthesis.
   always_comb begin
      if (combine_progress_ff < lntp_pkg::TAG_LENGTH &&
          step.ch == lntp_pkg::tag_char(1'b0, combine_progress_ff)) begin
         combine_step = combine_progress_ff + 4'd1;
      end else begin
         combine_step = is_open ? 4'd1 : 4'd0;
      end
      if (replace_progress_ff < lntp_pkg::TAG_LENGTH &&
          step.ch == lntp_pkg::tag_char(1'b1, replace_progress_ff)) begin
         replace_step = replace_progress_ff + 4'd1;
      end else begin
         replace_step = is_open ? 4'd1 : 4'd0;
      end
   end

   // The first completed tag wins; combine wins a tie.
   always_comb begin
      disposal_next = disposal_ff;
      if (disposal_ff == lntp_pkg::DISPOSAL_NONE) begin
         if (combine_step == lntp_pkg::TAG_LENGTH) begin
            disposal_next = lntp_pkg::DISPOSAL_COMBINE;
         end else if (replace_step == lntp_pkg::TAG_LENGTH) begin
            disposal_next = lntp_pkg::DISPOSAL_REPLACE;
         end
      end
      combine_progress_in = (combine_step == lntp_pkg::TAG_LENGTH) ? 4'd0 : combine_step;
      replace_progress_in = (replace_step == lntp_pkg::TAG_LENGTH) ? 4'd0 : replace_step;
   end

   // Matcher state; cleared at the end of every name.
   always_ff @(posedge clock) begin
      if (reset) begin
         combine_progress_ff <= '0;
         replace_progress_ff <= '0;
         disposal_ff         <= lntp_pkg::DISPOSAL_NONE;
      end else if (step.accept) begin
         if (step.last) begin
            combine_progress_ff <= '0;
            replace_progress_ff <= '0;
            disposal_ff         <= lntp_pkg::DISPOSAL_NONE;
         end else begin
            combine_progress_ff <= combine_progress_in;
            replace_progress_ff <= replace_progress_in;
            disposal_ff         <= disposal_next;
         end
      end
   end

endmodule

>>> rtl/lntp_timing.sv
// ----------------------------------------------------------------------------
// Timing tag scanner
// Parses the first '(' followed by decimal digits and "ms" and presents the
// digit value and parse status that include the current character.
// ----------------------------------------------------------------------------
module lntp_timing #(
   parameter int SUM_BITS = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lntp_pkg::step_type     step,
   output logic [SUM_BITS-1:0]    sum_next,
   output lntp_pkg::status_type   status_next
);

   localparam int WIDE_BITS = SUM_BITS + 4;

   lntp_pkg::phase_type  phase_ff;
   lntp_pkg::phase_type  phase_in;
   logic [SUM_BITS-1:0]  sum_ff;
   lntp_pkg::status_type status_latch_ff;
   lntp_pkg::status_type status_latch_in;
   logic [1:0]           tail_count_ff;
   logic [1:0]           tail_count_in;
   logic [1:0]           suffix_ok_ff;
   logic [1:0]           suffix_ok_in;
   logic                 is_digit;
   logic                 is_m;
   logic                 is_s;
   logic [3:0]           digit;
   logic [WIDE_BITS-1:0] sum_wide;
   logic [WIDE_BITS-1:0] product;
   logic [SUM_BITS-1:0]  sum_sat;
   logic [1:0]           tail_base;
   logic [1:0]           suffix_base;

   assign is_digit = (step.ch >= lntp_pkg::CHAR_ZERO) && (step.ch <= lntp_pkg::CHAR_NINE);
   assign is_m     = (step.ch == lntp_pkg::CHAR_UPPER_M) || (step.ch == lntp_pkg::CHAR_LOWER_M);
   assign is_s     = (step.ch == lntp_pkg::CHAR_UPPER_S) || (step.ch == lntp_pkg::CHAR_LOWER_S);
   assign digit    = step.ch[3:0];

   // Decimal accumulate as shift-add, saturating at the all-ones value.
   assign sum_wide = WIDE_BITS'(sum_ff);
   assign product  = (sum_wide << 3) + (sum_wide << 1) + WIDE_BITS'(digit);
   assign sum_sat  = (product > WIDE_BITS'({SUM_BITS{1'b1}})) ? {SUM_BITS{1'b1}}
                                                             : product[SUM_BITS-1:0];

   // Next state of the scan.
   always_comb begin
      phase_in        = phase_ff;
      sum_next        = sum_ff;
      status_latch_in = status_latch_ff;
      tail_base       = tail_count_ff;
      suffix_base     = suffix_ok_ff;
      tail_count_in   = tail_count_ff;
      suffix_ok_in    = suffix_ok_ff;
      case (phase_ff)
         lntp_pkg::PHASE_SEEK: begin
            if (step.ch == lntp_pkg::CHAR_OPEN_PAREN) begin
               phase_in = lntp_pkg::PHASE_FIRST;
            end
         end
         lntp_pkg::PHASE_FIRST: begin
            if (is_digit) begin
               sum_next = SUM_BITS'(digit);
               phase_in = lntp_pkg::PHASE_DIGITS;
            end else begin
               status_latch_in = lntp_pkg::STATUS_NO_DIGIT;
               phase_in        = lntp_pkg::PHASE_DONE;
            end
         end
         lntp_pkg::PHASE_DIGITS: begin
            if (is_digit) begin
               sum_next = sum_sat;
            end else begin
               // The first character after the digits already counts as tail.
               phase_in    = lntp_pkg::PHASE_TAIL;
               tail_base   = 2'd0;
               suffix_base = 2'd0;
            end
         end
         default: begin
         end
      endcase

      // Tail update, shared by the tail phase and the digit exit.
      if (phase_in == lntp_pkg::PHASE_TAIL) begin
         suffix_ok_in = suffix_base;
         if (tail_base == 2'd0 && is_m) begin
            suffix_ok_in[0] = 1'b1;
         end
         if (tail_base == 2'd1 && is_s) begin
            suffix_ok_in[1] = 1'b1;
         end
         tail_count_in = (tail_base == 2'd3) ? tail_base : tail_base + 2'd1;
      end
   end

   // Status as it would stand if this character ends the name.
   always_comb begin
      case (phase_in)
         lntp_pkg::PHASE_SEEK:   status_next = lntp_pkg::STATUS_NO_PAREN;
         lntp_pkg::PHASE_FIRST:  status_next = lntp_pkg::STATUS_NO_DIGIT;
         lntp_pkg::PHASE_DIGITS: status_next = lntp_pkg::STATUS_TOO_SHORT;
         lntp_pkg::PHASE_TAIL: begin
            if (tail_count_in != 2'd3) begin
               status_next = lntp_pkg::STATUS_TOO_SHORT;
            end else if (suffix_ok_in != 2'b11) begin
               status_next = lntp_pkg::STATUS_NO_MS;
            end else begin
               status_next = lntp_pkg::STATUS_OK;
            end
         end
         default:                status_next = status_latch_in;
      endcase
   end

   // Scan state; cleared at the end of every name.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lntp_pkg::PHASE_SEEK;
         sum_ff          <= '0;
         status_latch_ff <= lntp_pkg::STATUS_OK;
         tail_count_ff   <= '0;
         suffix_ok_ff    <= '0;
      end else if (step.accept) begin
         if (step.last) begin
            phase_ff        <= lntp_pkg::PHASE_SEEK;
            sum_ff          <= '0;
            status_latch_ff <= lntp_pkg::STATUS_OK;
            tail_count_ff   <= '0;
            suffix_ok_ff    <= '0;
         end else begin
            phase_ff        <= phase_in;
            sum_ff          <= sum_next;
            status_latch_ff <= status_latch_in;
            tail_count_ff   <= tail_count_in;
            suffix_ok_ff    <= suffix_ok_in;
         end
      end
   end

endmodule

>>> rtl/layer_name_tag_parser.sv
// The parser takes one character of a layer name per request, at most one
// per clock cycle, and emits one response in the cycle after the request that
// carries last. Each character is handled by the timing scanner and the
// disposal matcher as it is accepted; the response sits in an output register,
// and a new request is taken whenever that register is empty or is being
// read in the same cycle, so a stream of names runs at one character per
// cycle. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
// Layer name tag parser
// Extracts the frame duration, parse status and disposal mode from a layer
// name streamed one character at a time.
// ----------------------------------------------------------------------------
module layer_name_tag_parser #(
   parameter int SUM_BITS = 31
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [lntp_pkg::CHAR_BITS-1:0]         req_ch,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [lntp_pkg::DURATION_BITS-1:0]     rsp_duration_ms,
   output logic [lntp_pkg::STATUS_BITS-1:0]       rsp_parse_status,
   output logic [lntp_pkg::DISPOSAL_BITS-1:0]     rsp_disposal,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lntp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [lntp_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   logic [lntp_pkg::CSR_DATA_BITS-1:0] default_duration_ff;
   logic [lntp_pkg::CSR_DATA_BITS-1:0] zero_substitute_ff;
   lntp_pkg::step_type                 step;
   logic [SUM_BITS-1:0]                sum_next;
   lntp_pkg::status_type               status_next;
   lntp_pkg::disposal_type             disposal_next;
   logic [lntp_pkg::DURATION_BITS-1:0] duration_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [lntp_pkg::DURATION_BITS-1:0] duration_ff;
   logic [lntp_pkg::STATUS_BITS-1:0]   status_ff;
   logic [lntp_pkg::DISPOSAL_BITS-1:0] disposal_ff;

   // Handshakes.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;
   assign step.accept = req_valid && req_ready;
   assign step.last   = req_last;
   assign step.ch     = req_ch;

   // Configuration registers; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         default_duration_ff <= lntp_pkg::DEFAULT_DURATION_RESET;
         zero_substitute_ff  <= lntp_pkg::ZERO_SUBSTITUTE_RESET;
      end else if (csr_valid) begin
         if (csr_index == lntp_pkg::CSR_DEFAULT_DURATION) begin
            default_duration_ff <= csr_data;
         end
         if (csr_index == lntp_pkg::CSR_ZERO_SUBSTITUTE) begin
            zero_substitute_ff <= csr_data;
         end
      end
   end

   lntp_timing #(
      .SUM_BITS (SUM_BITS)
   ) u_timing (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .sum_next    (sum_next),
      .status_next (status_next)
   );

   lntp_disposal u_disposal (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .disposal_next (disposal_next)
   );

   // Duration selection: default on a failed parse, substitute for zero.
   always_comb begin
      if (status_next != lntp_pkg::STATUS_OK) begin
         duration_in = lntp_pkg::DURATION_BITS'(default_duration_ff);
      end else if (sum_next == '0) begin
         duration_in = lntp_pkg::DURATION_BITS'(zero_substitute_ff);
      end else begin
         duration_in = lntp_pkg::DURATION_BITS'(sum_next);
      end
   end

   // Response valid: set by a final character, cleared when read.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step.accept && step.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (step.accept && step.last) begin
         duration_ff <= duration_in;
         status_ff   <= status_next;
         disposal_ff <= disposal_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duration_ms  = duration_ff;
   assign rsp_parse_status = status_ff;
   assign rsp_disposal     = disposal_ff;

   // A final character always produces a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> rsp_valid)
      else $error("final character did not produce a response");

   // A character that is not final never creates a response.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last && !rsp_valid) |=> !rsp_valid)
      else $error("response appeared without a final character");

   // A failed parse falls back to a 16-bit configuration value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parse_status != lntp_pkg::STATUS_OK) |->
         (rsp_duration_ms[lntp_pkg::DURATION_BITS-1:lntp_pkg::CSR_DATA_BITS] == '0))
      else $error("failed parse carries a duration wider than the default");

   // Status and disposal stay within their defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_parse_status <= lntp_pkg::STATUS_NO_MS &&
                     rsp_disposal <= lntp_pkg::DISPOSAL_REPLACE))
      else $error("response carries an undefined code");

endmodule

>>> verif/layer_name_tag_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer name tag parser testbench
// Streams layer names into the parser one character per request and checks
// each response against a predictor in the testbench or a typed result. Short
// directed names come first, then random names under several register
// settings, with random idle gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------
module layer_name_tag_parser_tb;

   localparam int CLOCK_PERIOD  = 10;
   localparam int SUM_WIDTH     = 31;
   localparam int RANDOM_CHARS  = 1200;
   localparam int PHASE_CHARS   = 250;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int TIMEOUT_NS    = 5_000_000;

   localparam logic [63:0] SUM_MAX = (64'd1 << SUM_WIDTH) - 64'd1;
   localparam logic [lntp_pkg::CHAR_BITS-1:0] CLOSE_PAREN = 8'h29;
   localparam logic [8*9-1:0] COMBINE_TAG = "(combine)";
   localparam logic [8*9-1:0] REPLACE_TAG = "(replace)";

   // Indexes past the register list; writes there must be ignored.
   localparam logic [lntp_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_LOW  = 2'd2;
   localparam logic [lntp_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_HIGH = 2'd3;

   typedef struct packed {
      logic [lntp_pkg::DURATION_BITS-1:0] duration_ms;
      lntp_pkg::status_type               status;
      lntp_pkg::disposal_type             disposal;
   } name_result_type;

   typedef struct {
      string           text;
      int              odd_pos;
      logic [7:0]      odd_byte;
      bit              typed;
      name_result_type result;
   } directed_row_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [lntp_pkg::CHAR_BITS-1:0]      req_ch;
   logic                                req_last;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [lntp_pkg::DURATION_BITS-1:0]  rsp_duration_ms;
   logic [lntp_pkg::STATUS_BITS-1:0]    rsp_parse_status;
   logic [lntp_pkg::DISPOSAL_BITS-1:0]  rsp_disposal;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [lntp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [lntp_pkg::CSR_DATA_BITS-1:0]  csr_data;

   // Predictor copy of the registers and the scan state.
   logic [lntp_pkg::CSR_DATA_BITS-1:0] default_duration = lntp_pkg::DEFAULT_DURATION_RESET;
   logic [lntp_pkg::CSR_DATA_BITS-1:0] zero_sub         = lntp_pkg::ZERO_SUBSTITUTE_RESET;
   lntp_pkg::phase_type                scan_phase       = lntp_pkg::PHASE_SEEK;
   logic [lntp_pkg::DURATION_BITS-1:0] digit_acc        = '0;
   lntp_pkg::status_type               latched_status   = lntp_pkg::STATUS_OK;
   logic [1:0]                         tail_count       = '0;
   logic [1:0]                         suffix_bits      = '0;
   logic [lntp_pkg::PROGRESS_BITS-1:0] combine_prog     = '0;
   logic [lntp_pkg::PROGRESS_BITS-1:0] replace_prog     = '0;
   lntp_pkg::disposal_type             disposal_seen    = lntp_pkg::DISPOSAL_NONE;

   name_result_type  awaited_results[$];
   name_result_type  typed_results[int];
   directed_row_type directed_rows[$];
   logic [7:0]       name_buf[$];
   int               names_sent;
   int               names_finished;
   int               fault_count;
   int               random_chars;
   bit               no_idle;
   bit               hold_request;

   layer_name_tag_parser #(
      .SUM_BITS(SUM_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ch(req_ch),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_duration_ms(rsp_duration_ms),
      .rsp_parse_status(rsp_parse_status),
      .rsp_disposal(rsp_disposal),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Progress of one disposal tag matcher after one more character.
   function automatic logic [lntp_pkg::PROGRESS_BITS-1:0] step_tag(
         input logic [lntp_pkg::PROGRESS_BITS-1:0] prog,
         input logic [8*9-1:0]                     tag,
         input logic [lntp_pkg::CHAR_BITS-1:0]     c);
      if (prog < lntp_pkg::TAG_LENGTH && c == tag[8*(8-prog) +: 8]) return prog + 1'b1;
      return (c == lntp_pkg::CHAR_OPEN_PAREN) ? 4'd1 : 4'd0;
   endfunction

   function automatic void append_text(input string text);
      for (int i = 0; i < text.len(); i++) name_buf.push_back(text.getc(i));
   endfunction

   // Printable filler without an open paren, sometimes a non-ASCII byte.
   function automatic void add_filler(input int count);
      logic [7:0] c;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            c = 8'($urandom_range(128, 255));
         end else begin
            do c = 8'($urandom_range(32, 126)); while (c == lntp_pkg::CHAR_OPEN_PAREN);
         end
         name_buf.push_back(c);
      end
   endfunction

   // A disposal tag, whole, cut short, or in upper case.
   function automatic void add_disposal_tag();
      string text;
      int    sel;
      text = $urandom_range(0, 1) ? "(combine)" : "(replace)";
      sel = $urandom_range(0, 3);
      if (sel == 2) begin
         text = text.substr(0, $urandom_range(0, 7));
      end else if (sel == 3) begin
         text = text.toupper();
      end
      append_text(text);
   endfunction

   function automatic void typed_row(input string text,
                                     input logic [lntp_pkg::DURATION_BITS-1:0] duration,
                                     input lntp_pkg::status_type status,
                                     input lntp_pkg::disposal_type disposal);
      directed_row_type row;
      row.text     = text;
      row.odd_pos  = -1;
      row.odd_byte = '0;
      row.typed    = 1'b1;
      row.result   = '{duration, status, disposal};
      directed_rows.push_back(row);
   endfunction

   function automatic void checked_row(input string text, input int odd_pos,
                                       input logic [7:0] odd_byte);
      directed_row_type row;
      row.text     = text;
      row.odd_pos  = odd_pos;
      row.odd_byte = odd_byte;
      row.typed    = 1'b0;
      row.result   = '0;
      directed_rows.push_back(row);
   endfunction

   // Offer every character of name_buf as a request, last flagged on the end.
   task automatic send_name();
      int gap;
      names_sent++;
      foreach (name_buf[i]) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_ch    <= name_buf[i];
         req_last  <= (i == name_buf.size() - 1);
         do @(posedge clock); while (!req_ready);
      end
   endtask

   // Stop offering and wait until every expected response has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lntp_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [lntp_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response side: random stalls, and one long hold-off when asked.
   initial begin : receiver
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
         end
      end
   end

   // Track register writes, predict each accepted request and check responses.
   always @(posedge clock) begin : monitor
      name_result_type      want;
      logic [63:0]          grown;
      logic                 is_digit;
      logic                 tail_step;
      logic                 is_m;
      logic                 is_s;
      lntp_pkg::status_type status;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lntp_pkg::CSR_DEFAULT_DURATION: default_duration = csr_data;
               lntp_pkg::CSR_ZERO_SUBSTITUTE:  zero_sub = csr_data;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            // Disposal tags: the first one completed is kept.
            combine_prog = step_tag(combine_prog, COMBINE_TAG, req_ch);
            replace_prog = step_tag(replace_prog, REPLACE_TAG, req_ch);
            if (disposal_seen == lntp_pkg::DISPOSAL_NONE) begin
               if (combine_prog == lntp_pkg::TAG_LENGTH)
                  disposal_seen = lntp_pkg::DISPOSAL_COMBINE;
               else if (replace_prog == lntp_pkg::TAG_LENGTH)
                  disposal_seen = lntp_pkg::DISPOSAL_REPLACE;
            end
            if (combine_prog == lntp_pkg::TAG_LENGTH) combine_prog = '0;
            if (replace_prog == lntp_pkg::TAG_LENGTH) replace_prog = '0;

            // Timing tag: paren, digits, then the characters after them.
            is_digit  = (req_ch >= lntp_pkg::CHAR_ZERO) && (req_ch <= lntp_pkg::CHAR_NINE);
            is_m      = (req_ch == lntp_pkg::CHAR_UPPER_M) || (req_ch == lntp_pkg::CHAR_LOWER_M);
            is_s      = (req_ch == lntp_pkg::CHAR_UPPER_S) || (req_ch == lntp_pkg::CHAR_LOWER_S);
            tail_step = 1'b0;
            case (scan_phase)
               lntp_pkg::PHASE_SEEK: begin
                  if (req_ch == lntp_pkg::CHAR_OPEN_PAREN) scan_phase = lntp_pkg::PHASE_FIRST;
               end
               lntp_pkg::PHASE_FIRST: begin
                  if (is_digit) begin
                     digit_acc  = lntp_pkg::DURATION_BITS'(req_ch - lntp_pkg::CHAR_ZERO);
                     scan_phase = lntp_pkg::PHASE_DIGITS;
                  end else begin
                     latched_status = lntp_pkg::STATUS_NO_DIGIT;
                     scan_phase     = lntp_pkg::PHASE_DONE;
                  end
               end
               lntp_pkg::PHASE_DIGITS: begin
                  if (is_digit) begin
                     grown = 64'(digit_acc) * 64'd10 + 64'(req_ch - lntp_pkg::CHAR_ZERO);
                     digit_acc = (grown > SUM_MAX) ? SUM_MAX[lntp_pkg::DURATION_BITS-1:0]
                                                   : grown[lntp_pkg::DURATION_BITS-1:0];
                  end else begin
                     scan_phase  = lntp_pkg::PHASE_TAIL;
                     tail_count  = '0;
                     suffix_bits = '0;
                     tail_step   = 1'b1;
                  end
               end
               lntp_pkg::PHASE_TAIL: tail_step = 1'b1;
               default: ;
            endcase
            if (tail_step) begin
               if (tail_count == 2'd0 && is_m) suffix_bits[0] = 1'b1;
               if (tail_count == 2'd1 && is_s) suffix_bits[1] = 1'b1;
               if (tail_count < 2'd3) tail_count++;
            end

            // The last character closes the name and produces its response.
            if (req_last) begin
               case (scan_phase)
                  lntp_pkg::PHASE_SEEK:   status = lntp_pkg::STATUS_NO_PAREN;
                  lntp_pkg::PHASE_FIRST:  status = lntp_pkg::STATUS_NO_DIGIT;
                  lntp_pkg::PHASE_DIGITS: status = lntp_pkg::STATUS_TOO_SHORT;
                  lntp_pkg::PHASE_TAIL: begin
                     if (tail_count < 2'd3) status = lntp_pkg::STATUS_TOO_SHORT;
                     else if (suffix_bits != 2'b11) status = lntp_pkg::STATUS_NO_MS;
                     else status = lntp_pkg::STATUS_OK;
                  end
                  default: status = latched_status;
               endcase
               want.status   = status;
               want.disposal = disposal_seen;
               if (status != lntp_pkg::STATUS_OK)
                  want.duration_ms = lntp_pkg::DURATION_BITS'(default_duration);
               else if (digit_acc == '0)
                  want.duration_ms = lntp_pkg::DURATION_BITS'(zero_sub);
               else
                  want.duration_ms = digit_acc;
               if (typed_results.exists(names_finished)) want = typed_results[names_finished];
               awaited_results.push_back(want);
               names_finished++;

               scan_phase     = lntp_pkg::PHASE_SEEK;
               digit_acc      = '0;
               latched_status = lntp_pkg::STATUS_OK;
               tail_count     = '0;
               suffix_bits    = '0;
               combine_prog   = '0;
               replace_prog   = '0;
               disposal_seen  = lntp_pkg::DISPOSAL_NONE;
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("response with no name outstanding: duration_ms %0d", rsp_duration_ms);
               fault_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_duration_ms !== want.duration_ms) begin
                  $error("duration_ms: expected %0d, got %0d", want.duration_ms,
                         rsp_duration_ms);
                  fault_count++;
               end
               if (rsp_parse_status !== want.status) begin
                  $error("parse_status: expected %0d, got %0d", want.status, rsp_parse_status);
                  fault_count++;
               end
               if (rsp_disposal !== want.disposal) begin
                  $error("disposal: expected %0d, got %0d", want.disposal, rsp_disposal);
                  fault_count++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      int                                 phase;
      int                                 phase_chars;
      int                                 kind;
      int                                 count;
      int                                 sel;
      int                                 cut;
      logic [lntp_pkg::CSR_DATA_BITS-1:0] duration_value;
      logic [lntp_pkg::CSR_DATA_BITS-1:0] substitute_value;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_ch    = '0;
      req_last  = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed names under the reset register values.
      typed_row("a", 31'd100, lntp_pkg::STATUS_NO_PAREN, lntp_pkg::DISPOSAL_NONE);
      typed_row("(", 31'd100, lntp_pkg::STATUS_NO_DIGIT, lntp_pkg::DISPOSAL_NONE);
      typed_row("x(ms)", 31'd100, lntp_pkg::STATUS_NO_DIGIT, lntp_pkg::DISPOSAL_NONE);
      typed_row("(5", 31'd100, lntp_pkg::STATUS_TOO_SHORT, lntp_pkg::DISPOSAL_NONE);
      typed_row("(5ms", 31'd100, lntp_pkg::STATUS_TOO_SHORT, lntp_pkg::DISPOSAL_NONE);
      typed_row("(5ms)", 31'd5, lntp_pkg::STATUS_OK, lntp_pkg::DISPOSAL_NONE);
      typed_row("(0ms)", 31'd60, lntp_pkg::STATUS_OK, lntp_pkg::DISPOSAL_NONE);
      typed_row("(12MS)", 31'd12, lntp_pkg::STATUS_OK, lntp_pkg::DISPOSAL_NONE);
      typed_row("(7mx)", 31'd100, lntp_pkg::STATUS_NO_MS, lntp_pkg::DISPOSAL_NONE);
      typed_row("(99999999999ms)", 31'h7FFF_FFFF, lntp_pkg::STATUS_OK,
                lntp_pkg::DISPOSAL_NONE);
      typed_row("(combine)", 31'd100, lntp_pkg::STATUS_NO_DIGIT,
                lntp_pkg::DISPOSAL_COMBINE);
      typed_row("(replace)(combine)", 31'd100, lntp_pkg::STATUS_NO_DIGIT,
                lntp_pkg::DISPOSAL_REPLACE);
      checked_row("(2147483647ms)", -1, 8'h00);
      checked_row("((combine)", -1, 8'h00);
      checked_row("(20ms)(replace)(50ms)", -1, 8'h00);
      checked_row("layer (3mS) (combine)(replace)", -1, 8'h00);
      checked_row("(combin(combine)", -1, 8'h00);
      checked_row("(07ms)", -1, 8'h00);
      // Non-ASCII bytes and a zero byte are ordinary non-digit characters.
      checked_row("(8ms)x", 5, 8'hFF);
      checked_row("(4ms)z", 5, 8'h00);
      checked_row("(1?ms)", 2, 8'hB5);
      checked_row("?(6ms)", 0, 8'h80);

      foreach (directed_rows[r]) begin
         name_buf.delete();
         append_text(directed_rows[r].text);
         if (directed_rows[r].odd_pos >= 0)
            name_buf[directed_rows[r].odd_pos] = directed_rows[r].odd_byte;
         if (directed_rows[r].typed) typed_results[names_sent] = directed_rows[r].result;
         send_name();
      end
      wait_for_results();

      // Random names, one register setting per phase.
      phase = 0;
      while (random_chars < RANDOM_CHARS) begin
         case (phase)
            0: begin
               duration_value   = 16'd1;
               substitute_value = 16'hFFFF;
            end
            1: begin
               duration_value   = 16'hFFFF;
               substitute_value = 16'd1;
            end
            2: begin
               duration_value   = 16'd0;
               substitute_value = 16'd0;
            end
            default: begin
               duration_value   = 16'($urandom_range(1, 65535));
               substitute_value = 16'($urandom_range(1, 65535));
            end
         endcase
         write_csr(lntp_pkg::CSR_DEFAULT_DURATION, duration_value);
         write_csr(lntp_pkg::CSR_ZERO_SUBSTITUTE, substitute_value);
         if (phase == 0) begin
            write_csr(CSR_UNUSED_LOW, 16'($urandom_range(0, 65535)));
            write_csr(CSR_UNUSED_HIGH, 16'($urandom_range(0, 65535)));
         end
         no_idle = (phase == 1);
         // The response side holds off while names keep coming.
         if (phase == 2) hold_request = 1'b1;

         phase_chars = 0;
         while (phase_chars < PHASE_CHARS && random_chars < RANDOM_CHARS) begin
            name_buf.delete();
            kind = $urandom_range(0, 99);
            if (kind >= 85) begin
               // Noise: arbitrary bytes, zero included.
               count = $urandom_range(1, 10);
               repeat (count) begin
                  if ($urandom_range(0, 7) == 0) name_buf.push_back(lntp_pkg::CHAR_OPEN_PAREN);
                  else name_buf.push_back(8'($urandom_range(0, 255)));
               end
            end else begin
               add_filler($urandom_range(0, 4));
               if ($urandom_range(0, 4) == 0) add_disposal_tag();
               name_buf.push_back(lntp_pkg::CHAR_OPEN_PAREN);
               sel = $urandom_range(0, 99);
               if (sel < 85) count = $urandom_range(1, 4);
               else if (sel < 95) count = $urandom_range(5, 9);
               else count = $urandom_range(10, 14);
               repeat (count) name_buf.push_back(lntp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
               sel = $urandom_range(0, 9);
               if (sel < 8) begin
                  name_buf.push_back($urandom_range(0, 1) ? lntp_pkg::CHAR_UPPER_M
                                                          : lntp_pkg::CHAR_LOWER_M);
                  name_buf.push_back($urandom_range(0, 1) ? lntp_pkg::CHAR_UPPER_S
                                                          : lntp_pkg::CHAR_LOWER_S);
               end else if (sel == 8) begin
                  name_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
                  name_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
               end else begin
                  name_buf.push_back(lntp_pkg::CHAR_LOWER_M);
               end
               if ($urandom_range(0, 6) != 0) name_buf.push_back(CLOSE_PAREN);
               add_filler($urandom_range(0, 3));
               if ($urandom_range(0, 2) == 0) add_disposal_tag();
               if ($urandom_range(0, 5) == 0) append_text("(5ms)");
               // Some well-formed names are cut short.
               if (kind >= 70) begin
                  cut = $urandom_range(1, name_buf.size());
                  while (name_buf.size() > cut) void'(name_buf.pop_back());
               end
            end
            send_name();
            phase_chars  += name_buf.size();
            random_chars += name_buf.size();
         end
         wait_for_results();
         phase++;
      end

      if (fault_count == 0) begin
         $display("layer_name_tag_parser_tb: PASS");
      end else begin
         $display("layer_name_tag_parser_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("layer_name_tag_parser_tb: FAIL");
      $finish;
   end

endmodule

>>> layer_name_tag_parser.f
rtl/lntp_pkg.sv
rtl/lntp_disposal.sv
rtl/lntp_timing.sv
rtl/layer_name_tag_parser.sv
verif/layer_name_tag_parser_tb.sv
